/* design/msm_pkg.sv */
// types and constants shared by the multidrop serial master
// used by msm_ctrl, msm_dp and multidrop_serial_master_top
package msm_pkg;

  // input item kinds (tuser on the slave side)
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_RX      = 2'd1;
  localparam logic [1:0] OP_PAYLOAD = 2'd2;

  // result status codes
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_NRDY  = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  localparam logic [7:0] RESET_BYTE = 8'hff;
  localparam logic [7:0] ERR_BIT    = 8'h08;
  localparam logic [7:0] WR_RDY     = 8'h01;
  localparam logic [7:0] RD_RDY     = 8'h02;
  localparam logic [7:0] CMD_WRITE  = 8'h01;
  localparam logic [7:0] CMD_READ   = 8'h02;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  // source of the transmit byte in a result
  typedef enum logic [2:0] {
    SRC_ADDR,
    SRC_RST,
    SRC_CMD,
    SRC_IN,
    SRC_SUM,
    SRC_MEM,
    SRC_ZERO
  } tx_src_t;

  // one result to load into the output register
  typedef struct packed {
    logic       emit;
    tx_src_t    src;
    logic       tx_valid;
    logic       ninth;
    logic       rx_valid;
    logic [1:0] status;
    logic       last;
  } emit_t;

  // controller to datapath
  typedef struct packed {
    logic  latch_in;
    logic  load_start;
    logic  clr_acc;
    logic  store_byte;
    logic  idx_clr;
    logic  idx_inc;
    emit_t out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       out_free;
    logic [1:0] op;
    logic       echo_match;
    logic       sum_match;
    logic       in_zero;
    logic       err_bit;
    logic       wr_rdy;
    logic       rd_rdy;
    logic       cmd_write;
    logic       cmd_read;
    logic       count_last;
    logic       count_full;
    logic       idx_last;
  } dp_stat_t;

endpackage

/* design/multidrop_serial_master_top.sv */
// top level of the multidrop serial master (9-bit address/data framing)
// instantiates msm_ctrl and msm_dp, uses msm_pkg
//
// input stream: one transaction per item; tuser is the kind (start, byte
// received from the slave, payload byte to send), tdata carries slave address,
// command and the byte. output stream: one transaction per result, a byte to
// transmit with its ninth bit, a verified received byte, or a status; tlast
// marks the final result caused by one input item.
// an item is latched in one cycle and decoded in the next; it gives one or two
// results, or a block resend or block release of BLOCK_LEN bytes, which reads
// the block buffer and then emits, one buffer read and one emit per byte, as
// the block buffer has a single read port. items with no result go back to
// waiting after decode.
// one item is in work at a time; the next is taken as soon as the sequencer
// is done, while the last result may still sit in the output register.
// when the receiver stalls the output register holds and the sequencer waits.
// reset empties the output register and returns to the idle phase; the block
// buffer is not cleared, every entry is written before it is read.
module multidrop_serial_master_top #(
  parameter int BLOCK_LEN = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [msm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // slave_addr, command, in_byte
  input  logic [1:0]                     s_axis_tuser,  // op
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [msm_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // tx_byte, rx_data, status, zero fill
  output logic [msm_pkg::OUT_USER_W-1:0] m_axis_tuser,  // tx_valid, tx_ninth, rx_valid
  output logic                           m_axis_tlast   // last
);

  msm_pkg::dp_cmd_t  cmd;
  msm_pkg::dp_stat_t stat;

  msm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .stat         (stat),
    .cmd          (cmd)
  );

  msm_dp #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

/* design/msm_dp.sv */
// datapath of the multidrop serial master: input latch, transaction registers,
// block buffer, running sum and the output register; uses msm_pkg
module msm_dp #(
  parameter int BLOCK_LEN = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [1:0]                     s_axis_tuser,
  input  logic [msm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  msm_pkg::dp_cmd_t               cmd,
  output msm_pkg::dp_stat_t              stat,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [msm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [msm_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int AW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int CW = $clog2(BLOCK_LEN + 1);
  localparam logic [CW-1:0] COUNT_LAST = CW'(BLOCK_LEN - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(BLOCK_LEN);
  localparam logic [AW-1:0] IDX_LAST   = AW'(BLOCK_LEN - 1);

  logic [1:0]    in_op;
  logic [7:0]    in_addr;
  logic [7:0]    in_cmd;
  logic [7:0]    in_byte;
  logic [7:0]    target_addr;
  logic [7:0]    active_cmd;
  logic [CW-1:0] byte_count;
  logic [7:0]    running_sum;
  logic [AW-1:0] idx;
  logic [7:0]    rd_data;
  logic [7:0]    block_store [BLOCK_LEN];
  logic [7:0]    tx_sel;
  logic          out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_op   <= s_axis_tuser;
      in_addr <= s_axis_tdata[7:0];
      in_cmd  <= s_axis_tdata[15:8];
      in_byte <= s_axis_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_addr <= '0;
      active_cmd  <= '0;
      byte_count  <= '0;
      running_sum <= '0;
      idx         <= '0;
    end else begin
      if (cmd.load_start) begin
        target_addr <= in_addr;
        active_cmd  <= in_cmd;
      end
      if (cmd.load_start || cmd.clr_acc) begin
        byte_count  <= '0;
        running_sum <= '0;
      end else if (cmd.store_byte) begin
        byte_count  <= byte_count + 1'b1;
        running_sum <= running_sum + in_byte;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // block buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      block_store[byte_count[AW-1:0]] <= in_byte;
    end
    rd_data <= block_store[idx];
  end

  always_comb begin
    case (cmd.out.src)
      msm_pkg::SRC_ADDR: tx_sel = target_addr;
      msm_pkg::SRC_RST:  tx_sel = msm_pkg::RESET_BYTE;
      msm_pkg::SRC_CMD:  tx_sel = active_cmd;
      msm_pkg::SRC_IN:   tx_sel = in_byte;
      msm_pkg::SRC_SUM:  tx_sel = running_sum;
      msm_pkg::SRC_MEM:  tx_sel = rd_data;
      default:           tx_sel = msm_pkg::ZERO_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out.emit) begin
      m_axis_tdata[7:0]   <= cmd.out.tx_valid ? tx_sel : msm_pkg::ZERO_BYTE;
      m_axis_tdata[15:8]  <= cmd.out.rx_valid ? rd_data : msm_pkg::ZERO_BYTE;
      m_axis_tdata[17:16] <= cmd.out.status;
      m_axis_tdata[23:18] <= '0;
      m_axis_tuser        <= {cmd.out.rx_valid, cmd.out.ninth & cmd.out.tx_valid,
                              cmd.out.tx_valid};
      m_axis_tlast        <= cmd.out.last;
    end
  end

  always_comb begin
    stat.out_free   = out_free;
    stat.op         = in_op;
    stat.echo_match = (in_byte == target_addr);
    stat.sum_match  = (in_byte == running_sum);
    stat.in_zero    = (in_byte == msm_pkg::ZERO_BYTE);
    stat.err_bit    = |(in_byte & msm_pkg::ERR_BIT);
    stat.wr_rdy     = |(in_byte & msm_pkg::WR_RDY);
    stat.rd_rdy     = |(in_byte & msm_pkg::RD_RDY);
    stat.cmd_write  = (active_cmd == msm_pkg::CMD_WRITE);
    stat.cmd_read   = (active_cmd == msm_pkg::CMD_READ);
    stat.count_last = (byte_count == COUNT_LAST);
    stat.count_full = (byte_count == COUNT_FULL);
    stat.idx_last   = (idx == IDX_LAST);
  end

endmodule

/* design/msm_ctrl.sv */
// controller of the multidrop serial master: protocol phase and the sequencer
// that emits the results of one transaction; uses msm_pkg
module msm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  msm_pkg::dp_stat_t  stat,
  output msm_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ECHO, PH_STATUS, PH_LOAD, PH_ACK, PH_RDATA, PH_RSUM
  } phase_t;

  typedef enum logic [3:0] {
    S_WAIT, S_DECODE, S_ADDR, S_RST, S_CMD, S_FIN, S_PAY, S_SUM,
    S_BRD, S_BEMIT, S_NAK, S_RRD, S_REMIT, S_RDONE
  } state_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [1:0] fin_status, fin_status_next;

  assign s_axis_tready = (state == S_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WAIT;
      phase      <= PH_IDLE;
      fin_status <= msm_pkg::ST_BUSY;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      fin_status <= fin_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    fin_status_next = fin_status;
    cmd             = '0;
    cmd.out.src     = msm_pkg::SRC_ZERO;
    cmd.out.status  = msm_pkg::ST_BUSY;

    unique case (state)
      S_WAIT: begin
        if (s_axis_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_WAIT;
        case (stat.op)
          msm_pkg::OP_START: begin
            cmd.load_start = 1'b1;
            phase_next     = PH_ECHO;
            state_next     = S_ADDR;
          end
          msm_pkg::OP_PAYLOAD: begin
            if (phase == PH_LOAD) begin
              cmd.store_byte = 1'b1;
              state_next     = S_PAY;
            end
          end
          msm_pkg::OP_RX: begin
            case (phase)
              PH_ECHO: begin
                if (!stat.echo_match) begin
                  state_next = S_RST;
                end else begin
                  phase_next = PH_STATUS;
                  state_next = S_CMD;
                end
              end
              PH_STATUS: begin
                if (stat.err_bit) begin
                  phase_next = PH_ECHO;
                  state_next = S_RST;
                end else begin
                  cmd.clr_acc = 1'b1;
                  if (stat.cmd_write && stat.wr_rdy) begin
                    phase_next = PH_LOAD;
                  end else if (stat.cmd_read && stat.rd_rdy) begin
                    phase_next = PH_RDATA;
                  end else begin
                    phase_next      = PH_IDLE;
                    fin_status_next = (stat.cmd_write || stat.cmd_read) ?
                                      msm_pkg::ST_NRDY : msm_pkg::ST_UNSUP;
                    state_next      = S_FIN;
                  end
                end
              end
              PH_ACK: begin
                if (stat.in_zero) begin
                  phase_next      = PH_IDLE;
                  fin_status_next = msm_pkg::ST_OK;
                  state_next      = S_FIN;
                end else begin
                  cmd.idx_clr = 1'b1;
                  state_next  = S_BRD;
                end
              end
              PH_RDATA: begin
                cmd.store_byte = 1'b1;
                if (stat.count_last) begin
                  phase_next = PH_RSUM;
                end
              end
              PH_RSUM: begin
                if (!stat.sum_match) begin
                  cmd.clr_acc = 1'b1;
                  phase_next  = PH_RDATA;
                  state_next  = S_NAK;
                end else begin
                  phase_next  = PH_IDLE;
                  cmd.idx_clr = 1'b1;
                  state_next  = S_RRD;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      // address retry: reset byte then the address, both address frames
      S_RST: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.src      = msm_pkg::SRC_RST;
          cmd.out.tx_valid = 1'b1;
          cmd.out.ninth    = 1'b1;
          state_next       = S_ADDR;
        end
      end

      S_ADDR: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.src      = msm_pkg::SRC_ADDR;
          cmd.out.tx_valid = 1'b1;
          cmd.out.ninth    = 1'b1;
          cmd.out.last     = 1'b1;
          state_next       = S_WAIT;
        end
      end

      S_CMD: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.src      = msm_pkg::SRC_CMD;
          cmd.out.tx_valid = 1'b1;
          cmd.out.last     = 1'b1;
          state_next       = S_WAIT;
        end
      end

      S_FIN: begin
        if (stat.out_free) begin
          cmd.out.emit   = 1'b1;
          cmd.out.status = fin_status;
          cmd.out.last   = 1'b1;
          state_next     = S_WAIT;
        end
      end

      // payload byte goes straight out; the sum follows the final one
      S_PAY: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.src      = msm_pkg::SRC_IN;
          cmd.out.tx_valid = 1'b1;
          cmd.out.last     = !stat.count_full;
          if (stat.count_full) begin
            phase_next = PH_ACK;
            state_next = S_SUM;
          end else begin
            state_next = S_WAIT;
          end
        end
      end

      S_SUM: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.src      = msm_pkg::SRC_SUM;
          cmd.out.tx_valid = 1'b1;
          cmd.out.last     = 1'b1;
          state_next       = S_WAIT;
        end
      end

      // block resend, one buffer read then one emit per byte
      S_BRD: begin
        state_next = S_BEMIT;
      end

      S_BEMIT: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.src      = msm_pkg::SRC_MEM;
          cmd.out.tx_valid = 1'b1;
          if (stat.idx_last) begin
            state_next = S_SUM;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_BRD;
          end
        end
      end

      S_NAK: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.src      = msm_pkg::SRC_RST;
          cmd.out.tx_valid = 1'b1;
          cmd.out.last     = 1'b1;
          state_next       = S_WAIT;
        end
      end

      // verified read block released byte by byte
      S_RRD: begin
        state_next = S_REMIT;
      end

      S_REMIT: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.rx_valid = 1'b1;
          if (stat.idx_last) begin
            state_next = S_RDONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_RRD;
          end
        end
      end

      S_RDONE: begin
        if (stat.out_free) begin
          cmd.out.emit     = 1'b1;
          cmd.out.src      = msm_pkg::SRC_ZERO;
          cmd.out.tx_valid = 1'b1;
          cmd.out.status   = msm_pkg::ST_OK;
          cmd.out.last     = 1'b1;
          state_next       = S_WAIT;
        end
      end

      default: state_next = S_WAIT;
    endcase
  end

endmodule

/* design/msm_checker.sv */
// port-level checks for multidrop_serial_master_top, bound to the top level
// uses msm_pkg for field widths and status codes
module msm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [msm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [msm_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input logic                           m_axis_tlast
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // no transmit means a zero byte and no ninth bit
  a_tx_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[7:0] == msm_pkg::ZERO_BYTE && !m_axis_tuser[1])
    else $error("idle transmit field not zero");

  // released read bytes are busy, not final and carry no transmit
  a_rx_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |->
      !m_axis_tuser[0] && !m_axis_tlast && m_axis_tdata[17:16] == msm_pkg::ST_BUSY)
    else $error("bad read release result");

  // address frames only while busy
  a_ninth_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[17:16] == msm_pkg::ST_BUSY)
    else $error("address frame with final status");

endmodule

bind multidrop_serial_master_top msm_checker u_msm_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

/* tb/tb_top.sv */
// testbench for multidrop_serial_master_top: directed table, then random exchanges
// predicts results from its own model of the master or takes them from the directed table; needs msm_pkg and the rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         IN_DATA_W  = msm_pkg::IN_DATA_W;
  localparam int         OUT_DATA_W = msm_pkg::OUT_DATA_W;
  localparam int         OUT_USER_W = msm_pkg::OUT_USER_W;
  localparam logic [1:0] OP_START   = msm_pkg::OP_START;
  localparam logic [1:0] OP_RX      = msm_pkg::OP_RX;
  localparam logic [1:0] OP_PAYLOAD = msm_pkg::OP_PAYLOAD;
  localparam logic [1:0] ST_BUSY    = msm_pkg::ST_BUSY;
  localparam logic [1:0] ST_OK      = msm_pkg::ST_OK;
  localparam logic [1:0] ST_NRDY    = msm_pkg::ST_NRDY;
  localparam logic [1:0] ST_UNSUP   = msm_pkg::ST_UNSUP;
  localparam logic [7:0] RESET_BYTE = msm_pkg::RESET_BYTE;
  localparam logic [7:0] ERR_BIT    = msm_pkg::ERR_BIT;
  localparam logic [7:0] WR_RDY     = msm_pkg::WR_RDY;
  localparam logic [7:0] RD_RDY     = msm_pkg::RD_RDY;
  localparam logic [7:0] CMD_WRITE  = msm_pkg::CMD_WRITE;
  localparam logic [7:0] CMD_READ   = msm_pkg::CMD_READ;
  localparam logic [7:0] ZERO_BYTE  = msm_pkg::ZERO_BYTE;

  localparam int BLOCK_LEN   = 16;
  localparam int WORK_ITEMS  = 250;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 2 * BLOCK_LEN + 32;
  localparam int DIR_ROWS    = 25;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ECHO, PH_STATUS, PH_LOAD, PH_ACK, PH_RDATA, PH_RSUM
  } master_phase_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_ninth;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [1:0] status;
    logic       last;
  } serial_result_t;

  typedef struct packed {
    logic [1:0]     op;
    logic [7:0]     addr;
    logic [7:0]     cmd;
    logic [7:0]     data;
    logic           typed;
    serial_result_t want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  multidrop_serial_master_top #(.BLOCK_LEN(BLOCK_LEN)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // master model state
  master_phase_t m_phase = PH_IDLE;
  logic [7:0]    m_addr = 8'h00;
  logic [7:0]    m_cmd = 8'h00;
  int            m_count = 0;
  logic [7:0]    m_sum = 8'h00;
  logic [7:0]    m_block [BLOCK_LEN];

  serial_result_t step_out [$];
  serial_result_t awaited [$];
  serial_result_t want;
  int errors = 0;
  int work_items = 0;
  int results_seen = 0;
  int quiet = 0;
  int stall_left = 0;
  bit long_hold_done = 1'b0;
  bit steady = 1'b0;

  plan_row_t plan [DIR_ROWS] = '{
    // ignored while idle, and the unused kind
    '{OP_RX,      8'h00, 8'h00,     8'h55, 1'b0, '0},
    '{OP_PAYLOAD, 8'h00, 8'h00,     8'haa, 1'b0, '0},
    '{OP_UNUSED,  8'hff, 8'hff,     8'hff, 1'b0, '0},
    // wrong echo, then error bit in status, then write not ready
    '{OP_START,   8'h00, CMD_WRITE, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'h01, 1'b0, '0},
    '{OP_RX,      8'h00, 8'h00,     8'h00, 1'b1, '{1'b1, CMD_WRITE, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,   ERR_BIT, 1'b0, '0},
    '{OP_RX,      8'h00, 8'h00,     8'h00, 1'b1, '{1'b1, CMD_WRITE, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_NRDY, 1'b1}},
    // unsupported command at the top of the ranges
    '{OP_START,   8'hff, 8'hff,     8'h00, 1'b1, '{1'b1, 8'hff, 1'b1, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'hff, 1'b1, '{1'b1, 8'hff, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'hf7, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_UNSUP, 1'b1}},
    // read not ready
    '{OP_START,   8'ha5, CMD_READ,  8'h00, 1'b1, '{1'b1, 8'ha5, 1'b1, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'ha5, 1'b1, '{1'b1, CMD_READ, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'hf5, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_NRDY, 1'b1}},
    // read under way, then a new start abandons it
    '{OP_START,   8'h3c, CMD_READ,  8'h00, 1'b1, '{1'b1, 8'h3c, 1'b1, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'h3c, 1'b1, '{1'b1, CMD_READ, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'h02, 1'b0, '0},
    '{OP_RX,      8'h00, 8'h00,     8'h77, 1'b0, '0},
    '{OP_START,   8'h12, CMD_WRITE, 8'h00, 1'b1, '{1'b1, 8'h12, 1'b1, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'h12, 1'b1, '{1'b1, CMD_WRITE, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_RX,      8'h00, 8'h00,     8'h01, 1'b0, '0},
    // received byte during payload load is dropped
    '{OP_RX,      8'h00, 8'h00,     8'h9a, 1'b0, '0},
    '{OP_PAYLOAD, 8'h00, 8'h00,     8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1}},
    '{OP_PAYLOAD, 8'h00, 8'h00,     8'hff, 1'b1, '{1'b1, 8'hff, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1}}
  };

  function automatic serial_result_t frame(logic tv, logic [7:0] tb, logic nin, logic rv,
                                           logic [7:0] rd, logic [1:0] st, logic lst);
    serial_result_t r;
    r = '{tv, tb, nin, rv, rd, st, lst};
    return r;
  endfunction

  // reset byte, then the address again, both as address frames
  function automatic void resend_address();
    m_phase = PH_ECHO;
    step_out.push_back(frame(1'b1, RESET_BYTE, 1'b1, 1'b0, 8'h00, ST_BUSY, 1'b0));
    step_out.push_back(frame(1'b1, m_addr, 1'b1, 1'b0, 8'h00, ST_BUSY, 1'b1));
  endfunction

  function automatic void close_exchange(logic [1:0] st);
    m_phase = PH_IDLE;
    step_out.push_back(frame(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, st, 1'b1));
  endfunction

  // results of the master for one item; returns 0 when the item is ignored
  function automatic bit advance_master(logic [1:0] op, logic [7:0] addr, logic [7:0] cmd,
                                        logic [7:0] b);
    logic [7:0] s;
    step_out.delete();
    if (op == OP_START) begin
      m_addr = addr;
      m_cmd = cmd;
      m_count = 0;
      m_sum = 8'h00;
      m_phase = PH_ECHO;
      step_out.push_back(frame(1'b1, addr, 1'b1, 1'b0, 8'h00, ST_BUSY, 1'b1));
      return 1'b1;
    end
    if (op == OP_PAYLOAD) begin
      if (m_phase != PH_LOAD) return 1'b0;
      if (m_count >= BLOCK_LEN) m_count = 0;
      m_block[m_count] = b;
      m_sum = m_sum + b;
      m_count++;
      if (m_count < BLOCK_LEN) begin
        step_out.push_back(frame(1'b1, b, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1));
      end else begin
        step_out.push_back(frame(1'b1, b, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b0));
        step_out.push_back(frame(1'b1, m_sum, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1));
        m_phase = PH_ACK;
      end
      return 1'b1;
    end
    if (op != OP_RX) return 1'b0;
    case (m_phase)
      PH_ECHO: begin
        if (b != m_addr) begin
          resend_address();
        end else begin
          m_phase = PH_STATUS;
          step_out.push_back(frame(1'b1, m_cmd, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1));
        end
      end
      PH_STATUS: begin
        if ((b & ERR_BIT) != 8'h00) begin
          resend_address();
        end else begin
          m_count = 0;
          m_sum = 8'h00;
          if (m_cmd == CMD_WRITE) begin
            if ((b & WR_RDY) == 8'h00) close_exchange(ST_NRDY);
            else m_phase = PH_LOAD;
          end else if (m_cmd == CMD_READ) begin
            if ((b & RD_RDY) == 8'h00) close_exchange(ST_NRDY);
            else m_phase = PH_RDATA;
          end else begin
            close_exchange(ST_UNSUP);
          end
        end
      end
      PH_ACK: begin
        if (b == ZERO_BYTE) begin
          close_exchange(ST_OK);
        end else begin
          // nak: whole buffered block and its sum again
          s = 8'h00;
          for (int i = 0; i < BLOCK_LEN; i++) begin
            s = s + m_block[i];
            step_out.push_back(frame(1'b1, m_block[i], 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b0));
          end
          step_out.push_back(frame(1'b1, s, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1));
        end
      end
      PH_RDATA: begin
        if (m_count >= BLOCK_LEN) m_count = 0;
        m_block[m_count] = b;
        m_sum = m_sum + b;
        m_count++;
        if (m_count >= BLOCK_LEN) m_phase = PH_RSUM;
      end
      PH_RSUM: begin
        if (b != m_sum) begin
          m_count = 0;
          m_sum = 8'h00;
          m_phase = PH_RDATA;
          step_out.push_back(frame(1'b1, RESET_BYTE, 1'b0, 1'b0, 8'h00, ST_BUSY, 1'b1));
        end else begin
          for (int i = 0; i < BLOCK_LEN; i++)
            step_out.push_back(frame(1'b0, 8'h00, 1'b0, 1'b1, m_block[i], ST_BUSY, 1'b0));
          step_out.push_back(frame(1'b1, ZERO_BYTE, 1'b0, 1'b0, 8'h00, ST_OK, 1'b1));
          m_phase = PH_IDLE;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [7:0] rnd8();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // data bytes lean toward the extremes
  function automatic logic [7:0] rnd_data();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return rnd8();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit cut_short();
    return $urandom_range(0, 29) == 0;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] cmd, input logic [7:0] b,
                           input logic typed = 1'b0, input serial_result_t exp = '0);
    int gap;
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {b, cmd, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    void'(advance_master(op, addr, cmd, b));
    work_items++;
    if (typed) awaited.push_back(exp);
    else foreach (step_out[i]) awaited.push_back(step_out[i]);
  endtask

  // sender pauses: valid drops before waiting for the results
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    logic [31:0] r;
    r = $urandom;
    send_item(r[1:0], rnd8(), rnd8(), rnd8());
  endtask

  // one exchange, mostly well formed, sometimes broken off or with noise
  task automatic run_exchange();
    logic [7:0] addr, cmd, st, sum, resp;
    int kind;
    bit again;
    addr = rnd8();
    kind = $urandom_range(0, 11);
    if (kind >= 10) begin
      repeat ($urandom_range(1, 4)) send_noise();
      return;
    end
    if (kind < 5) cmd = CMD_WRITE;
    else if (kind < 9) cmd = CMD_READ;
    else begin
      cmd = rnd8();
      if (cmd == CMD_WRITE || cmd == CMD_READ) cmd = ~cmd;
    end
    send_item(OP_START, addr, cmd, rnd8());
    again = 1'b1;
    while (again) begin
      if ($urandom_range(0, 4) == 0) begin
        resp = rnd8();
        if (resp == addr) resp = ~addr;
        send_item(OP_RX, rnd8(), rnd8(), resp);
      end
      send_item(OP_RX, rnd8(), rnd8(), addr);
      if (cut_short()) return;
      again = $urandom_range(0, 5) == 0;
      if (again) send_item(OP_RX, rnd8(), rnd8(), rnd8() | ERR_BIT);
    end
    st = rnd8() & ~ERR_BIT;
    if (cmd == CMD_WRITE) begin
      if ($urandom_range(0, 5) == 0) st = st & ~WR_RDY;
      else st = st | WR_RDY;
      send_item(OP_RX, rnd8(), rnd8(), st);
      if ((st & WR_RDY) == 8'h00) return;
      for (int i = 0; i < BLOCK_LEN; i++) begin
        if ($urandom_range(0, 11) == 0) send_item(OP_RX, rnd8(), rnd8(), rnd8());
        send_item(OP_PAYLOAD, rnd8(), rnd8(), rnd_data());
        if (cut_short()) return;
      end
      repeat ($urandom_range(0, 2)) begin
        resp = rnd8();
        if (resp == ZERO_BYTE) resp = RESET_BYTE;
        send_item(OP_RX, rnd8(), rnd8(), resp);
      end
      send_item(OP_RX, rnd8(), rnd8(), ZERO_BYTE);
    end else if (cmd == CMD_READ) begin
      if ($urandom_range(0, 5) == 0) st = st & ~RD_RDY;
      else st = st | RD_RDY;
      send_item(OP_RX, rnd8(), rnd8(), st);
      if ((st & RD_RDY) == 8'h00) return;
      again = 1'b1;
      while (again) begin
        sum = 8'h00;
        for (int i = 0; i < BLOCK_LEN; i++) begin
          if ($urandom_range(0, 11) == 0) send_item(OP_PAYLOAD, rnd8(), rnd8(), rnd8());
          resp = rnd_data();
          sum = sum + resp;
          send_item(OP_RX, rnd8(), rnd8(), resp);
          if (cut_short()) return;
        end
        again = $urandom_range(0, 3) == 0;
        // a wrong sum is answered with the reset byte and the block comes again
        send_item(OP_RX, rnd8(), rnd8(), again ? (sum ^ (rnd8() | 8'h01)) : sum);
      end
    end else begin
      send_item(OP_RX, rnd8(), rnd8(), st);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, got %h", name, exp, act);
      errors++;
    end
  endtask

  // periods with no idling on either side
  initial begin
    forever begin
      repeat ($urandom_range(40, 200)) @(posedge clk);
      steady = $urandom_range(0, 3) == 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: tdata %h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = awaited.pop_front();
        check_field("tx_valid", 8'(want.tx_valid), 8'(m_axis_tuser[0]));
        check_field("tx_byte", want.tx_byte, m_axis_tdata[7:0]);
        check_field("tx_ninth", 8'(want.tx_ninth), 8'(m_axis_tuser[1]));
        check_field("rx_valid", 8'(want.rx_valid), 8'(m_axis_tuser[2]));
        check_field("rx_data", want.rx_data, m_axis_tdata[15:8]);
        check_field("status", 8'(want.status), 8'(m_axis_tdata[17:16]));
        check_field("last", 8'(want.last), 8'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results awaited", quiet, awaited.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, one long hold that backs the block up
  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = steady ? 0 : pick_gap();
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i])
      send_item(plan[i].op, plan[i].addr, plan[i].cmd, plan[i].data, plan[i].typed, plan[i].want);
    drain_results();
    while (work_items < WORK_ITEMS) begin
      run_exchange();
      if ($urandom_range(0, 7) == 0) drain_results();
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && awaited.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/msm_pkg.sv
design/msm_dp.sv
design/msm_ctrl.sv
design/multidrop_serial_master_top.sv
design/msm_checker.sv
tb/tb_top.sv
